[hdl/pau3_pkg.sv]
// shared constants, types and helpers for the 3x pixel art upscaler
// no dependencies; every other file in hdl except pau3_ram imports this package
package pau3_pkg;

   // line store depth and derived counter widths
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // fixed field widths
   localparam int PIX_W   = 8;
   localparam int CFG_W   = 11;
   localparam int COORD_W = 10;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   // register select, taken from paddr[2]
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // one source column: rows r-2, r-1 and r, or a picked top/mid/bottom
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } column_type;

   // one 3x3 output block
   typedef struct packed {
      logic [PIX_W-1:0] top_left;
      logic [PIX_W-1:0] top_mid;
      logic [PIX_W-1:0] top_right;
      logic [PIX_W-1:0] mid_left;
      logic [PIX_W-1:0] center_px;
      logic [PIX_W-1:0] mid_right;
      logic [PIX_W-1:0] bottom_left;
      logic [PIX_W-1:0] bottom_mid;
      logic [PIX_W-1:0] bottom_right;
   } block_type;

   // choose the neighbours of one block row, clamping at the top edge and, for the lower row, at the bottom edge
   function automatic column_type pick_rows(input column_type src, input logic lower,
                                            input logic y_zero);
      column_type res;
      if (!lower) begin
         res.mid = src.mid;
         res.top = y_zero ? src.mid : src.top;
         res.bot = src.bot;
      end else begin
         res.mid = src.bot;
         res.top = y_zero ? src.bot : src.mid;
         res.bot = src.bot;
      end
      return res;
   endfunction

endpackage

[hdl/pau3_req_if.sv]
// input channel: one source pixel word per handshake
// depends on pau3_pkg
interface pau3_req_if
   import pau3_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

[hdl/pau3_rsp_if.sv]
// result channel: one enlarged 3x3 block word per handshake
// depends on pau3_pkg
interface pau3_rsp_if
   import pau3_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] block_x;
   logic [COORD_W-1:0] block_y;
   logic [PIX_W-1:0]   top_left;
   logic [PIX_W-1:0]   top_mid;
   logic [PIX_W-1:0]   top_right;
   logic [PIX_W-1:0]   mid_left;
   logic [PIX_W-1:0]   center_px;
   logic [PIX_W-1:0]   mid_right;
   logic [PIX_W-1:0]   bottom_left;
   logic [PIX_W-1:0]   bottom_mid;
   logic [PIX_W-1:0]   bottom_right;
   logic               last_of_run;

   modport source (output valid, output block_x, output block_y, output top_left,
                   output top_mid, output top_right, output mid_left, output center_px,
                   output mid_right, output bottom_left, output bottom_mid,
                   output bottom_right, output last_of_run, input ready);
   modport sink   (input valid, input block_x, input block_y, input top_left,
                   input top_mid, input top_right, input mid_left, input center_px,
                   input mid_right, input bottom_left, input bottom_mid,
                   input bottom_right, input last_of_run, output ready);
endinterface

[hdl/pau3_ram.sv]
// generic single write port ram with registered, enabled read port
// no dependencies
module pau3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pau3_kernel.sv]
// scale3x equality rules: 3x3 neighbourhood in, 3x3 output block out
// depends on pau3_pkg
module pau3_kernel
   import pau3_pkg::*;
(
   input  column_type left_col,
   input  column_type mid_col,
   input  column_type right_col,
   output block_type  blk
);

   logic [PIX_W-1:0] a, b, c, d, e, f, g, h, i;
   logic             active;

   assign a = left_col.top;
   assign b = mid_col.top;
   assign c = right_col.top;
   assign d = left_col.mid;
   assign e = mid_col.mid;
   assign f = right_col.mid;
   assign g = left_col.bot;
   assign h = mid_col.bot;
   assign i = right_col.bot;

   // rules apply only where the cross is not flat
   assign active = (b != h) && (d != f);

   always_comb begin
      blk = '{default: e};
      if (active) begin
         blk.top_left     = (d == b) ? d : e;
         blk.top_mid      = (((d == b) && (e != c)) || ((b == f) && (e != a))) ? b : e;
         blk.top_right    = (b == f) ? f : e;
         blk.mid_left     = (((d == b) && (e != g)) || ((d == h) && (e != a))) ? d : e;
         blk.mid_right    = (((b == f) && (e != i)) || ((h == f) && (e != c))) ? f : e;
         blk.bottom_left  = (d == h) ? d : e;
         blk.bottom_mid   = (((d == h) && (e != i)) || ((h == f) && (e != g))) ? h : e;
         blk.bottom_right = (h == f) ? f : e;
      end
   end

endmodule

[hdl/pixel_art_upscale_3x_unit.sv]
// top level of the 3x pixel art upscaler: counters, line stores, column window,
// block sequencer and result register; uses pau3_pkg, pau3_req_if, pau3_rsp_if,
// pau3_ram and pau3_kernel
//
//   channel   direction  word                          handshake
//   req_chan  in         pixel_in                      valid/ready
//   rsp_chan  out        block_x..bottom_right, last   valid/ready
//   csr       in/out     image_width, image_height     apb, pready tied high
//
// one pixel accepted per cycle unless stage 1 is held; blocks pass stage 1, the
// sequencer and the result register. a pixel yields zero to four blocks, sent
// one per cycle while the output is free, so row ends and the last row hold input.
// line store data arrives the cycle after acceptance; stores are written as the
// pixel moves on. synchronous reset clears counters and valid bits, width=height=1.
// a stalled result port backs up through the sequencer into the input handshake.
module pixel_art_upscale_3x_unit
   import pau3_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   pau3_req_if.sink          req_chan,
   pau3_rsp_if.source        rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   // configuration registers
   logic [CFG_W-1:0] image_width_ff, image_width_in;
   logic [CFG_W-1:0] image_height_ff, image_height_in;

   // position counters
   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;

   // stage 0 signals
   logic [COL_W-1:0] w_last, col0;
   logic [ROW_W-1:0] h_last, row0;
   logic             accept;
   logic [3:0]       mask0;

   // stage 1: pixel waiting for line store data
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [3:0]       s1_mask_ff;
   logic             s1_move;
   logic [PIX_W-1:0] older_rd, newer_rd;
   column_type       cur;
   logic             fwd;

   // last line store write, for a same-address read that missed it
   logic             last_valid_ff;
   logic [COL_W-1:0] last_addr_ff;
   logic [PIX_W-1:0] last_older_ff, last_newer_ff;

   // column window: columns c-1 and c-2
   column_type       win0_ff, win1_ff;

   // stage 2: block sequencer
   logic [3:0]       s2_mask_ff, s2_mask_in;
   column_type       s2_c0_ff, s2_c1_ff, s2_c2_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic [3:0]       low_bit, rest_mask;
   logic             sel_lower, sel_last_kind;
   logic             emit, s2_free;
   column_type       left_raw, mid_raw, right_raw;
   column_type       left_col, mid_col, right_col;
   logic             y_zero;
   block_type        blk;
   logic [COL_W-1:0] blk_x;
   logic [ROW_W-1:0] blk_y;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   block_type        rsp_blk_ff;
   logic [COL_W-1:0] rsp_x_ff;
   logic [ROW_W-1:0] rsp_y_ff;
   logic             rsp_last_ff;

   // apb port
   logic             cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (cfg_write) begin
         unique case (paddr[2])
            REG_IMAGE_WIDTH:  image_width_in  = pwdata[CFG_W-1:0];
            REG_IMAGE_HEIGHT: image_height_in = pwdata[CFG_W-1:0];
            default:          image_width_in  = image_width_ff;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (paddr[2])
         REG_IMAGE_WIDTH:  prdata = {{(DATA_W-CFG_W){1'b0}}, image_width_ff};
         REG_IMAGE_HEIGHT: prdata = {{(DATA_W-CFG_W){1'b0}}, image_height_ff};
         default:          prdata = '0;
      endcase
   end

   // effective last column and last row, clamped to the supported range
   always_comb begin
      if (image_width_ff == '0) begin
         w_last = '0;
      end else if ({{(DATA_W-CFG_W){1'b0}}, image_width_ff} > DATA_W'(MAX_WIDTH)) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(image_width_ff - CFG_W'(1));
      end
      if (image_height_ff == '0) begin
         h_last = '0;
      end else if ({{(DATA_W-CFG_W){1'b0}}, image_height_ff} > DATA_W'(MAX_HEIGHT)) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(image_height_ff - CFG_W'(1));
      end
   end

   // stage 0: position of the incoming pixel and the blocks it completes
   assign col0   = (column_count_ff > w_last) ? w_last : column_count_ff;
   assign row0   = (row_count_ff > h_last) ? h_last : row_count_ff;
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_move;

   // bit 0: upper row prev column, 1: upper row last column,
   // bit 2: lower row prev column, 3: lower row last column
   always_comb begin
      mask0[0] = (row0 != '0) && (col0 != '0);
      mask0[1] = (row0 != '0) && (col0 == w_last);
      mask0[2] = (row0 == h_last) && (col0 != '0);
      mask0[3] = (row0 == h_last) && (col0 == w_last);
   end

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (col0 >= w_last) begin
            column_count_in = '0;
            row_count_in    = (row0 >= h_last) ? '0 : ROW_W'(row0 + ROW_W'(1));
         end else begin
            column_count_in = COL_W'(col0 + COL_W'(1));
            row_count_in    = row0;
         end
      end
   end

   // line stores: rows r-2 and r-1
   pau3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) older_row_store (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (cur.mid),
      .rd_en   (accept),
      .rd_addr (col0),
      .rd_data (older_rd)
   );

   pau3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) newer_row_store (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (col0),
      .rd_data (newer_rd)
   );

   // stage 1: current column, forwarding the previous write on a one-wide image
   assign fwd     = last_valid_ff && (last_addr_ff == s1_col_ff);
   assign cur.top = fwd ? last_older_ff : older_rd;
   assign cur.mid = fwd ? last_newer_ff : newer_rd;
   assign cur.bot = s1_pixel_ff;
   assign s1_move = s1_valid_ff && s2_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // stage 2: pick the next pending block
   assign low_bit       = s2_mask_ff & (~s2_mask_ff + 4'd1);
   assign rest_mask     = s2_mask_ff & ~low_bit;
   assign sel_lower     = (low_bit[2] || low_bit[3]);
   assign sel_last_kind = (low_bit[1] || low_bit[3]);
   assign out_free      = !rsp_valid_ff || rsp_chan.ready;
   assign emit          = (s2_mask_ff != '0) && out_free;
   assign s2_free       = (s2_mask_ff == '0) || (emit && (rest_mask == '0));

   always_comb begin
      s2_mask_in = s2_mask_ff;
      if (s1_move) begin
         s2_mask_in = s1_mask_ff;
      end else if (emit) begin
         s2_mask_in = rest_mask;
      end
   end

   // neighbourhood columns and rows, clamped at the image edges
   always_comb begin
      if (sel_last_kind) begin
         left_raw  = (s2_col_ff == '0) ? s2_c0_ff : s2_c1_ff;
         mid_raw   = s2_c0_ff;
         right_raw = s2_c0_ff;
         blk_x     = s2_col_ff;
      end else begin
         left_raw  = (s2_col_ff == COL_W'(1)) ? s2_c1_ff : s2_c2_ff;
         mid_raw   = s2_c1_ff;
         right_raw = s2_c0_ff;
         blk_x     = COL_W'(s2_col_ff - COL_W'(1));
      end
      if (sel_lower) begin
         blk_y  = s2_row_ff;
         y_zero = (s2_row_ff == '0);
      end else begin
         blk_y  = ROW_W'(s2_row_ff - ROW_W'(1));
         y_zero = (s2_row_ff == ROW_W'(1));
      end
      left_col  = pick_rows(left_raw, sel_lower, y_zero);
      mid_col   = pick_rows(mid_raw, sel_lower, y_zero);
      right_col = pick_rows(right_raw, sel_lower, y_zero);
   end

   pau3_kernel kernel (
      .left_col  (left_col),
      .mid_col   (mid_col),
      .right_col (right_col),
      .blk       (blk)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CFG_W'(1);
         image_height_ff <= CFG_W'(1);
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         s2_mask_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         last_valid_ff   <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         s1_valid_ff     <= s1_valid_in;
         s2_mask_ff      <= s2_mask_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (s1_move) begin
            last_valid_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_chan.pixel_in;
         s1_col_ff   <= col0;
         s1_row_ff   <= row0;
         s1_mask_ff  <= mask0;
      end
      if (s1_move) begin
         last_addr_ff  <= s1_col_ff;
         last_older_ff <= cur.mid;
         last_newer_ff <= s1_pixel_ff;
         win0_ff       <= cur;
         win1_ff       <= win0_ff;
         s2_c0_ff      <= cur;
         s2_c1_ff      <= win0_ff;
         s2_c2_ff      <= win1_ff;
         s2_col_ff     <= s1_col_ff;
         s2_row_ff     <= s1_row_ff;
      end
      if (emit) begin
         rsp_blk_ff  <= blk;
         rsp_x_ff    <= blk_x;
         rsp_y_ff    <= blk_y;
         rsp_last_ff <= (rest_mask == '0);
      end
   end

   // result port
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.block_x      = COORD_W'(rsp_x_ff);
   assign rsp_chan.block_y      = COORD_W'(rsp_y_ff);
   assign rsp_chan.top_left     = rsp_blk_ff.top_left;
   assign rsp_chan.top_mid      = rsp_blk_ff.top_mid;
   assign rsp_chan.top_right    = rsp_blk_ff.top_right;
   assign rsp_chan.mid_left     = rsp_blk_ff.mid_left;
   assign rsp_chan.center_px    = rsp_blk_ff.center_px;
   assign rsp_chan.mid_right    = rsp_blk_ff.mid_right;
   assign rsp_chan.bottom_left  = rsp_blk_ff.bottom_left;
   assign rsp_chan.bottom_mid   = rsp_blk_ff.bottom_mid;
   assign rsp_chan.bottom_right = rsp_blk_ff.bottom_right;
   assign rsp_chan.last_of_run  = rsp_last_ff;

endmodule
